// ----- src/hnt_pkg.sv -----
// ============================================================================
// hnt_pkg
// Shared types and constants of the hierarchical node transform.
// ============================================================================
package hnt_pkg;

   localparam int NUM_REGS = 8;
   localparam int REG_W    = 64;
   localparam int ADDR_W   = 3;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   // Request as it travels from the front queue to the back end.
   typedef struct packed {
      logic [5:0]         node_index;
      logic               is_root;
      logic [5:0]         parent;
      logic               do_store;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] scl_x;
      logic signed [31:0] scl_y;
      logic signed [31:0] scl_z;
   } node_req_type;

   // Clamp a wide sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      begin
         if (v > 64'(SAT_MAX)) begin
            r = SAT_MAX;
         end else if (v < 64'(SAT_MIN)) begin
            r = SAT_MIN;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

endpackage

// ----- src/hnt_front.sv -----
// ============================================================================
// hnt_front
// Accept requests, classify root and store cases, and queue them.
// ============================================================================
module hnt_front
   import hnt_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int DEPTH     = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [5:0]         req_node_index,
   input  logic signed [6:0]  req_parent_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_quat_x,
   input  logic signed [31:0] req_quat_y,
   input  logic signed [31:0] req_quat_z,
   input  logic signed [31:0] req_quat_w,
   input  logic signed [31:0] req_scl_x,
   input  logic signed [31:0] req_scl_y,
   input  logic signed [31:0] req_scl_z,
   output logic               q_valid,
   input  logic               q_take,
   output node_req_type       q_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   node_req_type   mem_ff [DEPTH];
   logic [PW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]    cnt_ff, cnt_in;
   node_req_type   item;
   logic           push;

   always_comb begin
      item            = '0;
      item.node_index = req_node_index;
      item.is_root    = req_parent_index[6] || (32'(req_parent_index) >= MAX_NODES);
      item.parent     = req_parent_index[5:0];
      item.do_store   = (32'(req_node_index) < MAX_NODES);
      item.pos_x  = req_pos_x;  item.pos_y  = req_pos_y;  item.pos_z  = req_pos_z;
      item.quat_x = req_quat_x; item.quat_y = req_quat_y;
      item.quat_z = req_quat_z; item.quat_w = req_quat_w;
      item.scl_x  = req_scl_x;  item.scl_y  = req_scl_y;  item.scl_z  = req_scl_z;
   end

   assign req_stall = (cnt_ff == (PW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push   ? ((32'(wp_ff) == DEPTH-1) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = q_take ? ((32'(rp_ff) == DEPTH-1) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= item;
      end
   end
endmodule

// ----- src/hnt_back.sv -----
// ============================================================================
// hnt_back
// Sequencer around one shared multiplier: quaternion, local, global, world.
// ============================================================================
module hnt_back
   import hnt_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_take,
   input  node_req_type       q_data,
   input  logic [REG_W-1:0]   world_ff [NUM_REGS],
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_world_c0,
   output logic signed [31:0] rsp_world_c1,
   output logic signed [31:0] rsp_world_c2,
   output logic signed [31:0] rsp_world_c3,
   output logic signed [31:0] rsp_global_c0,
   output logic signed [31:0] rsp_global_c1,
   output logic signed [31:0] rsp_global_c2,
   output logic signed [31:0] rsp_global_c3,
   output logic               rsp_last_row
);
   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_QUAT = 3'd1, ST_LOC = 3'd2,
                          ST_GLB = 3'd3, ST_WLD = 3'd4, ST_OUT = 3'd5;

   logic [2:0]          st_ff, st_in;
   logic [5:0]          k_ff, k_in;       // step counter
   node_req_type        rq_ff;
   logic signed [63:0]  q9_ff [9];        // xx yy zz xy xz yz xw yw zw, unclamped
   logic signed [31:0]  loc_ff [16];
   logic signed [31:0]  glb_ff [16];
   logic signed [31:0]  wld_ff [16];
   logic signed [63:0]  acc_ff;
   logic signed [31:0]  ma, mb;
   logic signed [63:0]  prod_ff;
   logic                pv_ff;            // product register valid
   logic [5:0]          pk_ff;            // step that made prod_ff
   logic signed [31:0]  par_rd_ff;
   logic signed [31:0]  store_mem [MAX_NODES*16];
   logic [1:0]          row_ff;
   logic signed [31:0]  rot [9];
   logic signed [63:0]  fl;

   // rotation terms from the stored quaternion products
   always_comb begin
      rot[0] = sat32(64'(ONE) - 64'sd2 * (q9_ff[1] + q9_ff[2]));
      rot[1] = sat32(64'sd2 * (q9_ff[3] + q9_ff[8]));
      rot[2] = sat32(64'sd2 * (q9_ff[4] - q9_ff[7]));
      rot[3] = sat32(64'sd2 * (q9_ff[3] - q9_ff[8]));
      rot[4] = sat32(64'(ONE) - 64'sd2 * (q9_ff[0] + q9_ff[2]));
      rot[5] = sat32(64'sd2 * (q9_ff[5] + q9_ff[6]));
      rot[6] = sat32(64'sd2 * (q9_ff[4] + q9_ff[7]));
      rot[7] = sat32(64'sd2 * (q9_ff[5] - q9_ff[6]));
      rot[8] = sat32(64'(ONE) - 64'sd2 * (q9_ff[0] + q9_ff[1]));
   end

   function automatic logic signed [31:0] wsel(input logic [REG_W-1:0] w [NUM_REGS],
                                                input logic [3:0] idx);
      logic [REG_W-1:0] r;
      begin
         r = w[{idx[3:2], idx[1]}];
         return idx[0] ? r[63:32] : r[31:0];
      end
   endfunction

   // operand select: one product per cycle
   // QUAT k 0..8, LOC k 0..8 (row k/3, col k%3), GLB/WLD k 0..63 (i,j,k)
   logic [1:0] gi, gj, gk;
   assign gi = k_ff[5:4];
   assign gj = k_ff[3:2];
   assign gk = k_ff[1:0];

   always_comb begin
      ma = '0; mb = '0;
      case (st_ff)
         ST_QUAT: begin
            case (k_ff[3:0])
               4'd0: begin ma = rq_ff.quat_x; mb = rq_ff.quat_x; end
               4'd1: begin ma = rq_ff.quat_y; mb = rq_ff.quat_y; end
               4'd2: begin ma = rq_ff.quat_z; mb = rq_ff.quat_z; end
               4'd3: begin ma = rq_ff.quat_x; mb = rq_ff.quat_y; end
               4'd4: begin ma = rq_ff.quat_x; mb = rq_ff.quat_z; end
               4'd5: begin ma = rq_ff.quat_y; mb = rq_ff.quat_z; end
               4'd6: begin ma = rq_ff.quat_x; mb = rq_ff.quat_w; end
               4'd7: begin ma = rq_ff.quat_y; mb = rq_ff.quat_w; end
               default: begin ma = rq_ff.quat_z; mb = rq_ff.quat_w; end
            endcase
         end
         ST_LOC: begin
            ma = (k_ff < 6'd3) ? rq_ff.scl_x : (k_ff < 6'd6) ? rq_ff.scl_y : rq_ff.scl_z;
            mb = rot[k_ff[3:0]];
         end
         ST_GLB: begin
            ma = loc_ff[{gi, gk}];
            mb = par_rd_ff;
         end
         ST_WLD: begin
            // a root's global matrix is its local one; read it there, since the
            // copy into glb_ff lands in the cycle after the world pass starts
            ma = rq_ff.is_root ? loc_ff[{gi, gk}] : glb_ff[{gi, gk}];
            mb = wsel(world_ff, {gk, gj});
         end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // floor shift of the registered product
   assign fl = prod_ff >>> FRAC_BITS;

   logic last_step;
   always_comb begin
      case (st_ff)
         ST_QUAT, ST_LOC: last_step = (k_ff == 6'd8);
         ST_GLB, ST_WLD:  last_step = (k_ff == 6'd63);
         default:         last_step = 1'b0;
      endcase
   end

   // parent read for the next step: address from k_in of GLB
   logic [5:0]    rd_k;
   logic [AW-1:0] node_a, par_a;
   logic [AW+3:0] rd_addr;
   assign node_a  = AW'(rq_ff.node_index);
   assign par_a   = AW'(rq_ff.parent);
   assign rd_k    = (st_ff == ST_GLB) ? k_ff + 6'd1 : 6'd0;
   assign rd_addr = {par_a, rd_k[1:0], rd_k[3:2]};

   logic take_out;
   assign take_out = rsp_valid && !rsp_stall;
   assign q_take   = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      st_in = st_ff;
      k_in  = k_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) begin st_in = ST_QUAT; k_in = '0; end
         ST_QUAT: begin k_in = last_step ? '0 : k_ff + 6'd1;
                        if (last_step) st_in = ST_LOC; end
         ST_LOC:  begin k_in = last_step ? '0 : k_ff + 6'd1;
                        if (last_step) st_in = rq_ff.is_root ? ST_WLD : ST_GLB; end
         ST_GLB:  begin k_in = k_ff + 6'd1; if (last_step) st_in = ST_WLD; end
         ST_WLD:  begin k_in = k_ff + 6'd1; if (last_step) st_in = ST_OUT; end
         ST_OUT:  if (take_out && rsp_last_row) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   logic [2:0] pst_ff;   // stage of the product in flight

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; k_ff <= '0; pv_ff <= 1'b0; row_ff <= '0;
      end else begin
         st_ff <= st_in; k_ff <= k_in;
         pv_ff <= (st_ff == ST_QUAT) || (st_ff == ST_LOC) ||
                  (st_ff == ST_GLB) || (st_ff == ST_WLD);
         if (take_out) row_ff <= row_ff + 2'd1;
      end
      if (q_take) rq_ff <= q_data;
      prod_ff   <= 64'(ma) * 64'(mb);
      pk_ff     <= k_ff;
      pst_ff    <= st_ff;
      par_rd_ff <= store_mem[(st_ff == ST_GLB) ? rd_addr : {par_a, 4'd0}];
      // writeback of the registered product
      if (pv_ff) begin
         case (pst_ff)
            ST_QUAT: q9_ff[pk_ff[3:0]] <= fl;
            ST_LOC: begin
               case (pk_ff[3:0])
                  4'd0: loc_ff[0]  <= sat32(fl);  4'd1: loc_ff[1]  <= sat32(fl);
                  4'd2: loc_ff[2]  <= sat32(fl);  4'd3: loc_ff[4]  <= sat32(fl);
                  4'd4: loc_ff[5]  <= sat32(fl);  4'd5: loc_ff[6]  <= sat32(fl);
                  4'd6: loc_ff[8]  <= sat32(fl);  4'd7: loc_ff[9]  <= sat32(fl);
                  default: loc_ff[10] <= sat32(fl);
               endcase
               if (pk_ff[3:0] == 4'd8 && rq_ff.is_root) begin
                  glb_ff[0] <= loc_ff[0]; glb_ff[1] <= loc_ff[1]; glb_ff[2] <= loc_ff[2];
                  glb_ff[3] <= '0; glb_ff[4] <= loc_ff[4]; glb_ff[5] <= loc_ff[5];
                  glb_ff[6] <= loc_ff[6]; glb_ff[7] <= '0; glb_ff[8] <= loc_ff[8];
                  glb_ff[9] <= loc_ff[9]; glb_ff[10] <= sat32(fl); glb_ff[11] <= '0;
                  glb_ff[12] <= rq_ff.pos_x; glb_ff[13] <= rq_ff.pos_y;
                  glb_ff[14] <= rq_ff.pos_z; glb_ff[15] <= ONE;
               end
            end
            ST_GLB, ST_WLD: begin
               if (pk_ff[1:0] == 2'd0) acc_ff <= fl;
               else                    acc_ff <= acc_ff + fl;
               if (pk_ff[1:0] == 2'd3) begin
                  if (pst_ff == ST_GLB) glb_ff[pk_ff[5:2]] <= sat32(acc_ff + fl);
                  else                  wld_ff[pk_ff[5:2]] <= sat32(acc_ff + fl);
               end
            end
            default: ;
         endcase
      end
      if (st_ff == ST_LOC && k_ff == 6'd0) begin
         loc_ff[3] <= '0; loc_ff[7] <= '0; loc_ff[11] <= '0;
         loc_ff[12] <= rq_ff.pos_x; loc_ff[13] <= rq_ff.pos_y;
         loc_ff[14] <= rq_ff.pos_z; loc_ff[15] <= ONE;
      end
      // store the global matrix one element a cycle during the world pass
      if (st_ff == ST_WLD && k_ff[5:4] == 2'd1 && rq_ff.do_store)
         store_mem[{node_a, k_ff[3:0]}] <= glb_ff[k_ff[3:0]];
   end

   assign rsp_valid     = (st_ff == ST_OUT);
   assign rsp_row_index = row_ff;
   assign rsp_last_row  = (row_ff == 2'd3);
   assign rsp_world_c0  = wld_ff[{row_ff, 2'd0}];
   assign rsp_world_c1  = wld_ff[{row_ff, 2'd1}];
   assign rsp_world_c2  = wld_ff[{row_ff, 2'd2}];
   assign rsp_world_c3  = wld_ff[{row_ff, 2'd3}];
   assign rsp_global_c0 = glb_ff[{row_ff, 2'd0}];
   assign rsp_global_c1 = glb_ff[{row_ff, 2'd1}];
   assign rsp_global_c2 = glb_ff[{row_ff, 2'd2}];
   assign rsp_global_c3 = glb_ff[{row_ff, 2'd3}];
endmodule

// ----- src/hierarchical_node_transform.sv -----
// ============================================================================
// hierarchical_node_transform
// Scene-graph node transform: local SRT, parent chain and world product.
// ============================================================================
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | node, parent, pos, quat, scale
// rsp     | out       | rsp_valid / rsp_stall | four rows, global and world
// csr     | in        | csr_write_enable      | 64-bit world matrix half-row
//
// In the back end a child request passes through the idle state that takes it,
// 9 quaternion products, 9 local products, 64 global and 64 world
// multiply-accumulates on one shared 32x32 multiplier, then four response
// rows. A root skips the global pass.
// Reset loads the world matrix with identity; the node store is not cleared.
// A stalled response holds the back end; the two-entry front queue keeps taking
// requests until it fills, then raises req_stall.
// ============================================================================
module hierarchical_node_transform
   import hnt_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [5:0]         req_node_index,
   input  logic signed [6:0]  req_parent_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_quat_x,
   input  logic signed [31:0] req_quat_y,
   input  logic signed [31:0] req_quat_z,
   input  logic signed [31:0] req_quat_w,
   input  logic signed [31:0] req_scl_x,
   input  logic signed [31:0] req_scl_y,
   input  logic signed [31:0] req_scl_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_world_c0,
   output logic signed [31:0] rsp_world_c1,
   output logic signed [31:0] rsp_world_c2,
   output logic signed [31:0] rsp_world_c3,
   output logic signed [31:0] rsp_global_c0,
   output logic signed [31:0] rsp_global_c1,
   output logic signed [31:0] rsp_global_c2,
   output logic signed [31:0] rsp_global_c3,
   output logic               rsp_last_row,
   input  logic               csr_write_enable,
   input  logic [ADDR_W-1:0]  csr_index,
   input  logic [REG_W-1:0]   csr_write_data
);
   localparam logic [REG_W-1:0] ONE64 = REG_W'(1) << FRAC_BITS;

   logic [REG_W-1:0] world_ff [NUM_REGS];
   logic             q_valid, q_take;
   node_req_type     q_data;

   // world matrix registers, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            world_ff[r] <= (r == 0 || r == 5) ? ONE64 :
                           (r == 2 || r == 7) ? (ONE64 << 32) : '0;
         end
      end else if (csr_write_enable) begin
         world_ff[csr_index] <= csr_write_data;
      end
   end

   hnt_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_node_index, .req_parent_index,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_quat_x, .req_quat_y, .req_quat_z,
      .req_quat_w, .req_scl_x, .req_scl_y, .req_scl_z,
      .q_valid, .q_take, .q_data
   );

   hnt_back #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data, .world_ff,
      .rsp_valid, .rsp_stall, .rsp_row_index,
      .rsp_world_c0, .rsp_world_c1, .rsp_world_c2, .rsp_world_c3,
      .rsp_global_c0, .rsp_global_c1, .rsp_global_c2, .rsp_global_c3,
      .rsp_last_row
   );
endmodule

// ----- src/hnt_checker.sv -----
// ============================================================================
// hnt_checker
// Port-level checks of the node transform.
// ============================================================================
module hnt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_row_index,
   input logic       rsp_last_row
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == (rsp_row_index == 2'd3)))
      else $error("last_row does not match row 3");

   a_next_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_row) |=>
         (rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("rows out of order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_row_index)))
      else $error("stalled response changed");
endmodule

bind hierarchical_node_transform hnt_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_row_index, .rsp_last_row
);
